### rtl/range_max_segment_tree_defines.svh
// ----------------------------------------------------------------------------
// range_max_segment_tree_defines.svh
// Assertion macros used by the range maximum segment tree top level.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Constants, payload types and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned NODE_COUNT   = 2 * MAX_ELEMENTS;
  localparam int unsigned ADDR_W       = $clog2(NODE_COUNT);
  localparam int unsigned BOUND_W      = ADDR_W + 1;      // holds 2*MAX_ELEMENTS
  localparam int unsigned POS_W        = 11;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CMP_W        = (POS_W > BOUND_W) ? POS_W : BOUND_W;

  localparam logic [COUNT_W-1:0]      COUNT_RESET = 11'd1024;
  localparam logic [VAL_W-1:0]        SIGN_FLIP   = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MIN     = 32'sh8000_0000;

  typedef enum logic [0:0] {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  element_value;
    logic [POS_W-1:0]         query_low;
    logic [POS_W-1:0]         query_high;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  max_value;
    logic                     range_error;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_QUERY  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  typedef struct packed {
    logic clr_step;   // write one cleared node
    logic start_set;  // write leaf, fetch its sibling
    logic start_qry;  // load query bounds
    logic upd_step;   // write one ancestor
    logic qry_step;   // walk one tree level of the query
    logic out_load;   // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic set_ok;
    logic upd_last;
    logic qry_done;
    logic out_busy;
  } dp_stat_t;

  // Unsigned max; values are kept in offset-binary form.
  function automatic logic [VAL_W-1:0] bigger(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    bigger = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### rtl/rmst_ram.sv
// ----------------------------------------------------------------------------
// rmst_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  output      logic [WIDTH-1:0]         rdata0_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output      logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

### rtl/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: clear sweep, set walk-up, query walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire rmst_pkg::cmd_e       in_cmd_i,
  output      logic                 in_ready_o,
  input  wire rmst_pkg::dp_stat_t   stat_i,
  output      rmst_pkg::ctrl_cmd_t  cmd_o
);
  import rmst_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_QUERY) begin
            cmd_o.start_qry = 1'b1;
            state_d         = ST_QUERY;
          end else if (stat_i.set_ok) begin
            cmd_o.start_set = 1'b1;
            state_d         = ST_UPDATE;
          end
          // out-of-range set: taken and dropped
        end
      end
      ST_UPDATE: begin
        cmd_o.upd_step = 1'b1;
        if (stat_i.upd_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (stat_i.qry_done) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.qry_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rmst_dp.sv
// ----------------------------------------------------------------------------
// rmst_dp
// Datapath: tree RAM, walk registers, query accumulator, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rmst_pkg::in_t              in_data_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [rmst_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  wire rmst_pkg::ctrl_cmd_t        cmd_i,
  output      rmst_pkg::dp_stat_t         stat_o,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      rmst_pkg::out_t             out_data_o
);
  import rmst_pkg::*;

  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ELEMENTS);

  // control state
  logic [COUNT_W-1:0] count_q;
  logic [ADDR_W-1:0]  clr_q;
  logic               take_l_q, take_l_d;
  logic               take_r_q, take_r_d;
  logic               out_valid_q, out_valid_d;

  // payload
  logic [ADDR_W-1:0]  node_q, node_d;
  logic [VAL_W-1:0]   cur_q, cur_d;
  logic [BOUND_W-1:0] left_q, left_d;
  logic [BOUND_W-1:0] right_q, right_d;
  logic [VAL_W-1:0]   best_q, best_d;
  logic               err_q, err_d;
  out_t               out_q, out_d;

  logic [CMP_W-1:0]   count_ext, count_eff, pos_ext, lo_ext, hi_ext;
  logic               qry_ok;
  logic [ADDR_W-1:0]  leaf, parent;
  logic [VAL_W-1:0]   biased_in, upd_max, acc_l, acc_r;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr0, ram_raddr1;
  logic [VAL_W-1:0]   ram_wdata, ram_rdata0, ram_rdata1;

  // bounds check against the count in use, limited to the tree size
  always_comb begin
    count_ext = CMP_W'(count_q);
    count_eff = (count_ext > MAX_CMP) ? MAX_CMP : count_ext;
    pos_ext   = CMP_W'(in_data_i.position);
    lo_ext    = CMP_W'(in_data_i.query_low);
    hi_ext    = CMP_W'(in_data_i.query_high);
    qry_ok    = (lo_ext != '0) && (hi_ext <= count_eff) && (lo_ext <= hi_ext);
  end

  assign leaf      = ADDR_W'(MAX_CMP + pos_ext - CMP_W'(1));
  assign parent    = node_q >> 1;
  assign biased_in = $unsigned(in_data_i.element_value) ^ SIGN_FLIP;
  assign upd_max   = bigger(cur_q, ram_rdata0);
  assign acc_l     = take_l_q ? ram_rdata0 : '0;
  assign acc_r     = take_r_q ? ram_rdata1 : '0;

  // RAM ports
  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.start_set | cmd_i.upd_step;
    ram_waddr = parent;
    ram_wdata = upd_max;
    if (cmd_i.clr_step) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.start_set) begin
      ram_waddr = leaf;
      ram_wdata = biased_in;
    end
    if (cmd_i.start_set) begin
      ram_raddr0 = leaf ^ ADDR_W'(1);
    end else if (cmd_i.upd_step) begin
      ram_raddr0 = parent ^ ADDR_W'(1);
    end else begin
      ram_raddr0 = left_q[ADDR_W-1:0];
    end
    ram_raddr1 = ADDR_W'(right_q - BOUND_W'(1));
  end

  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODE_COUNT)
  ) u_tree_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .rdata0_o (ram_rdata0),
    .raddr1_i (ram_raddr1),
    .rdata1_o (ram_rdata1)
  );

  // walk registers
  always_comb begin
    node_d   = node_q;
    cur_d    = cur_q;
    left_d   = left_q;
    right_d  = right_q;
    err_d    = err_q;
    take_l_d = 1'b0;
    take_r_d = 1'b0;
    best_d   = bigger(best_q, bigger(acc_l, acc_r));
    if (cmd_i.start_set) begin
      node_d = leaf;
      cur_d  = biased_in;
    end
    if (cmd_i.upd_step) begin
      node_d = parent;
      cur_d  = upd_max;
    end
    if (cmd_i.start_qry) begin
      // bad query: empty walk, result stays at the minimum
      err_d   = !qry_ok;
      best_d  = '0;
      left_d  = qry_ok ? BOUND_W'(MAX_CMP + lo_ext - CMP_W'(1)) : '0;
      right_d = qry_ok ? BOUND_W'(MAX_CMP + hi_ext) : '0;
    end
    if (cmd_i.qry_step) begin
      take_l_d = left_q[0];
      take_r_d = right_q[0];
      left_d   = (left_q + BOUND_W'(left_q[0])) >> 1;
      right_d  = (right_q - BOUND_W'(right_q[0])) >> 1;
    end
  end

  // output register
  always_comb begin
    out_d             = out_q;
    out_valid_d       = out_valid_q & ~out_ready_i;
    if (cmd_i.out_load) begin
      out_d.max_value   = $signed(best_q ^ SIGN_FLIP);
      out_d.range_error = err_q;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= COUNT_RESET;
      clr_q       <= '0;
      take_l_q    <= 1'b0;
      take_r_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      take_l_q    <= take_l_d;
      take_r_q    <= take_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    cur_q   <= cur_d;
    left_q  <= left_d;
    right_q <= right_d;
    best_q  <= best_d;
    err_q   <= err_d;
    out_q   <= out_d;
  end

  always_comb begin
    stat_o.clr_last = (clr_q == ADDR_W'(NODE_COUNT - 1));
    stat_o.set_ok   = (pos_ext != '0) && (pos_ext <= count_eff);
    stat_o.upd_last = (parent == ADDR_W'(1));
    stat_o.qry_done = !(left_q < right_q);
    stat_o.out_busy = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/range_max_segment_tree.sv
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Range maximum segment tree over signed 32-bit elements, positions 1..N.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i): one item is a set
//    (write one element) or a query (max over query_low..query_high).
//  - Output channel (out_valid_o/out_ready_i/out_data_o): one item per
//    query, none per set. Bad bounds give range_error = 1 and the minimum.
//  - cfg_we_i/cfg_wdata_i write element_count; write only while idle.
//  - One item at a time. A set is the leaf write, then one ancestor per
//    cycle up the 10 tree levels. A query is the accept, one tree level
//    per cycle for up to 11 levels (two RAM read ports, one per bound), a
//    step to close the walk, then the output register load, which waits
//    while that register is still busy. A bad query has an empty walk.
//  - Reset: all 2048 nodes of the tree RAM are swept to the minimum value,
//    one node per cycle; in_ready_o stays low until the sweep ends.
//  - Output stall: a finished result waits in the output register and the
//    next item is still taken; a later query result waits until that
//    register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_max_segment_tree_defines.svh"

module range_max_segment_tree (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire rmst_pkg::in_t                in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      rmst_pkg::out_t               out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rmst_pkg::COUNT_W-1:0] cfg_wdata_i
);
  import rmst_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer: decides what the datapath does each cycle.
  rmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath: tree RAM plus walk and result registers.
  rmst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // At most one RAM-using operation per cycle.
  `RMST_ASSERT(a_one_op,
               $onehot0({ctrl_cmd.clr_step, ctrl_cmd.start_set, ctrl_cmd.start_qry,
                         ctrl_cmd.upd_step, ctrl_cmd.qry_step}),
               "rmst: overlapping datapath commands")
  // A result never overwrites one still waiting.
  `RMST_ASSERT(a_no_overwrite, !(ctrl_cmd.out_load && out_valid_o && !out_ready_i),
               "rmst: output register overwritten")
  // An error result always carries the minimum value.
  `RMST_ASSERT(a_err_min,
               !(out_valid_o && out_data_o.range_error) || (out_data_o.max_value == INT_MIN),
               "rmst: error result not minimum")
  // Nothing is taken in the cycle after a query starts.
  `RMST_ASSERT_NEXT(a_qry_busy, ctrl_cmd.start_qry, !in_ready_o, "rmst: input taken during query")

endmodule

`default_nettype wire
